/* rtl/core/lsbb_pkg.sv */
// shared widths and constants for the lane segment bounding box block
package lsbb_pkg;

  localparam int unsigned IN_W  = 24;
  localparam int unsigned WID_W = 12;
  localparam int unsigned OUT_W = 25;
  localparam int unsigned EXT_W = IN_W + 3;
  localparam int unsigned K_W   = 12;

  localparam logic signed [EXT_W-1:0] BOX_LOW  = -27'sd8390656;
  localparam logic signed [EXT_W-1:0] BOX_HIGH = 27'sd8390655;

  localparam int unsigned RES_W = 4 * OUT_W + 1;

endpackage

/* rtl/core/lane_segment_bounding_box.sv */
// top level of the lane segment bounding box block
// usage:
//   requests enter on the push/full side: a segment is taken at a rising edge
//   with push_i high and full_o low. results leave on the empty/pop side: the
//   oldest box is on the result ports while empty_o is low and is taken at a
//   rising edge with pop_i high.
//   one request per cycle is sustained while full_o stays low. after the edge
//   that takes a request, it passes the front register, the middle queue,
//   two product stages, twelve offset search stages (one result bit each),
//   one edge stage and the result queue, and then shows on the result ports.
//   the back issues only while the 32-entry result queue has room for all
//   work in flight, so a stalled receiver first fills the result queue,
//   then the middle queue and the front register, and then full_o rises.
//   no request is dropped.
//   reset empties all queues and the pipeline; nothing else needs clearing.
//   a degenerate segment gives zero bounds with the degenerate flag set.
module lane_segment_bounding_box #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [23:0] start_x_i,
  input  logic [23:0] start_y_i,
  input  logic [23:0] end_x_i,
  input  logic [23:0] end_y_i,
  input  logic [11:0] start_width_i,
  input  logic [11:0] end_width_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [24:0] box_x_min_o,
  output logic [24:0] box_x_max_o,
  output logic [24:0] box_y_min_o,
  output logic [24:0] box_y_max_o,
  output logic        degenerate_o
);

  localparam int unsigned MW        = 25 - FRAC_BITS;
  localparam int unsigned QW        = 6 * MW + 2 * lsbb_pkg::WID_W + 1;
  localparam int unsigned OUT_DEPTH = 32;
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OW        = lsbb_pkg::OUT_W;

  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic [QW-1:0] mid_wdata, mid_rdata;
  logic          res_push, res_full;
  logic [lsbb_pkg::RES_W-1:0] res_wdata, res_rdata;

  lsbb_front #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW),
    .QW        (QW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .start_width_i (start_width_i),
    .end_width_i   (end_width_i),
    .q_push_o      (mid_push),
    .q_data_o      (mid_wdata),
    .q_full_i      (mid_full)
  );

  lsbb_fifo #(
    .WIDTH (QW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  lsbb_back #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW),
    .QW        (QW),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_data_i   (mid_rdata),
    .q_pop_o    (mid_pop),
    .res_push_o (res_push),
    .res_data_o (res_wdata),
    .res_pop_i  (pop_i && !empty_o)
  );

  lsbb_fifo #(
    .WIDTH (lsbb_pkg::RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o)
  );

  assign box_x_min_o  = res_rdata[3*OW+1 +: OW];
  assign box_x_max_o  = res_rdata[2*OW+1 +: OW];
  assign box_y_min_o  = res_rdata[OW+1 +: OW];
  assign box_y_max_o  = res_rdata[1 +: OW];
  assign degenerate_o = res_rdata[0];

  // credit scheme must never overflow the result queue
  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_mid_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("issue from empty middle queue");

  a_mid_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("middle queue overflow");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && degenerate_o) |-> (box_x_min_o == '0 && box_y_max_o == '0))
    else $error("degenerate result with nonzero bounds");

endmodule

/* rtl/core/lsbb_fifo.sv */
// small register queue with registered storage and occupancy count
module lsbb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/lsbb_front.sv */
// front stage: takes segment requests, rounds endpoints, classifies degenerate
module lsbb_front #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned MW        = 25 - FRAC_BITS,
  parameter int unsigned QW        = 6 * MW + 2 * lsbb_pkg::WID_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [lsbb_pkg::IN_W-1:0]     start_x_i,
  input  logic [lsbb_pkg::IN_W-1:0]     start_y_i,
  input  logic [lsbb_pkg::IN_W-1:0]     end_x_i,
  input  logic [lsbb_pkg::IN_W-1:0]     end_y_i,
  input  logic [lsbb_pkg::WID_W-1:0]    start_width_i,
  input  logic [lsbb_pkg::WID_W-1:0]    end_width_i,
  output logic                          q_push_o,
  output logic [QW-1:0]                 q_data_o,
  input  logic                          q_full_i
);

  localparam int unsigned IW = lsbb_pkg::IN_W;

  function automatic logic [MW-1:0] to_metre(input logic [IW-1:0] v);
    logic [IW:0] vs;
    logic [IW:0] mag;
    logic [IW:0] rnd;
    logic [MW-1:0] m;
    vs  = {v[IW-1], v};
    mag = vs[IW] ? (~vs + 1'b1) : vs;
    rnd = (mag + (IW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    m   = rnd[MW-1:0];
    return vs[IW] ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [MW-1:0] abs_diff(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [MW:0] d;
    d = {b[MW-1], b} - {a[MW-1], a};
    d = d[MW] ? (~d + 1'b1) : d;
    return d[MW-1:0];
  endfunction

  logic          valid_q;
  logic [QW-1:0] data_q, data_d;
  logic          ready;
  logic [MW-1:0] x1, y1, x2, y2, adx, ady;
  logic          degen;

  assign ready    = !valid_q || !q_full_i;
  assign full_o   = !ready;
  assign q_push_o = valid_q && !q_full_i;
  assign q_data_o = data_q;

  always_comb begin
    x1     = to_metre(start_x_i);
    y1     = to_metre(start_y_i);
    x2     = to_metre(end_x_i);
    y2     = to_metre(end_y_i);
    adx    = abs_diff(x1, x2);
    ady    = abs_diff(y1, y2);
    degen  = (x1 == x2) && (y1 == y2);
    data_d = {x1, y1, x2, y2, adx, ady, start_width_i, end_width_i, degen};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/core/lsbb_back.sv */
// back pipeline: squared terms, bit-serial offset search, box edges
module lsbb_back #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned MW        = 25 - FRAC_BITS,
  parameter int unsigned QW        = 6 * MW + 2 * lsbb_pkg::WID_W + 1,
  parameter int unsigned OUT_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [QW-1:0]                  q_data_i,
  output logic                           q_pop_o,
  output logic                           res_push_o,
  output logic [lsbb_pkg::RES_W-1:0]     res_data_o,
  input  logic                           res_pop_i
);

  localparam int unsigned WW  = lsbb_pkg::WID_W;
  localparam int unsigned KW  = lsbb_pkg::K_W;
  localparam int unsigned EW  = lsbb_pkg::EXT_W;
  localparam int unsigned OW  = lsbb_pkg::OUT_W;
  localparam int unsigned SW  = 2 * MW + 1;
  localparam int unsigned CWW = MW + WW;
  localparam int unsigned TW  = 2 * CWW + 2;
  localparam int unsigned NW  = 4 * MW + 1;
  localparam int unsigned CNW = $clog2(OUT_DEPTH + 1);

  logic [CNW-1:0] cnt_q, cnt_d;
  logic           issue, res_take;

  assign issue    = !q_empty_i && (cnt_q < CNW'(OUT_DEPTH));
  assign q_pop_o  = issue;
  assign res_take = res_pop_i;

  always_comb begin
    cnt_d = cnt_q;
    if (issue && !res_take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (res_take && !issue) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // stage a: squares and products
  logic [MW-1:0]  in_adx, in_ady;
  logic [WW-1:0]  in_w1, in_w2;
  logic [NW-1:0]  in_meta;
  logic           va_q;
  logic [SW-1:0]  sa_q;
  logic [CWW-1:0] cwa_q [4];
  logic [NW-1:0]  ma_q;

  assign in_meta = {q_data_i[QW-1 -: 4*MW], q_data_i[0]};
  assign in_adx  = q_data_i[2*WW+1+MW +: MW];
  assign in_ady  = q_data_i[2*WW+1 +: MW];
  assign in_w1   = q_data_i[WW+1 +: WW];
  assign in_w2   = q_data_i[1 +: WW];

  // stage b: squared scaled widths
  logic           vb_q;
  logic [SW-1:0]  sb_q;
  logic [TW-1:0]  rb_q [4];
  logic [NW-1:0]  mb_q;

  // search stages
  logic           vs_q [KW];
  logic [SW-1:0]  ss_q [KW];
  logic [NW-1:0]  ms_q [KW];
  logic [TW-1:0]  rs_q [KW][4];
  logic [TW-1:0]  ps_q [KW][4];
  logic [TW-1:0]  ks_q [KW][4];
  logic [KW-1:0]  kk_q [KW][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      va_q  <= issue;
      vb_q  <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q     <= SW'(in_adx) * SW'(in_adx) + SW'(in_ady) * SW'(in_ady);
    cwa_q[0] <= CWW'(in_ady) * CWW'(in_w1);
    cwa_q[1] <= CWW'(in_adx) * CWW'(in_w1);
    cwa_q[2] <= CWW'(in_ady) * CWW'(in_w2);
    cwa_q[3] <= CWW'(in_adx) * CWW'(in_w2);
    ma_q     <= in_meta;
    sb_q     <= sa_q;
    mb_q     <= ma_q;
    for (int l = 0; l < 4; l++) begin
      rb_q[l] <= TW'(cwa_q[l]) * TW'(cwa_q[l]);
    end
  end

  for (genvar j = 0; j < KW; j++) begin : g_step
    localparam int unsigned BIT = KW - 1 - j;
    logic           v_prev;
    logic [SW-1:0]  s_prev;
    logic [NW-1:0]  m_prev;
    logic [TW-1:0]  r_prev [4];
    logic [TW-1:0]  p_prev [4];
    logic [TW-1:0]  k_prev_s [4];
    logic [KW-1:0]  k_prev [4];
    logic [TW-1:0]  trial [4];
    logic           ok [4];

    if (j == 0) begin : g_first
      always_comb begin
        v_prev = vb_q;
        s_prev = sb_q;
        m_prev = mb_q;
        for (int l = 0; l < 4; l++) begin
          r_prev[l]   = rb_q[l];
          p_prev[l]   = '0;
          k_prev_s[l] = '0;
          k_prev[l]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_prev = vs_q[j-1];
        s_prev = ss_q[j-1];
        m_prev = ms_q[j-1];
        for (int l = 0; l < 4; l++) begin
          r_prev[l]   = rs_q[j-1][l];
          p_prev[l]   = ps_q[j-1][l];
          k_prev_s[l] = ks_q[j-1][l];
          k_prev[l]   = kk_q[j-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = p_prev[l] + (k_prev_s[l] << (BIT + 1)) + (TW'(s_prev) << (2 * BIT));
        ok[l]    = (trial[l] <= r_prev[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j] <= 1'b0;
      end else begin
        vs_q[j] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      ss_q[j] <= s_prev;
      ms_q[j] <= m_prev;
      for (int l = 0; l < 4; l++) begin
        rs_q[j][l] <= r_prev[l];
        ps_q[j][l] <= ok[l] ? trial[l] : p_prev[l];
        ks_q[j][l] <= ok[l] ? (k_prev_s[l] + (TW'(s_prev) << BIT)) : k_prev_s[l];
        kk_q[j][l] <= k_prev[l] | (KW'(ok[l]) << BIT);
      end
    end
  end

  // final stage: corners, extremes, saturation
  function automatic logic [OW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] t;
    t = v;
    if (t < lsbb_pkg::BOX_LOW) begin
      t = lsbb_pkg::BOX_LOW;
    end
    if (t > lsbb_pkg::BOX_HIGH) begin
      t = lsbb_pkg::BOX_HIGH;
    end
    return t[OW-1:0];
  endfunction

  function automatic logic signed [EW-1:0] to_fix(input logic [MW-1:0] m);
    logic signed [EW-1:0] e;
    e = $signed({{(EW-MW){m[MW-1]}}, m});
    return e <<< FRAC_BITS;
  endfunction

  logic [MW-1:0]        fx1, fy1, fx2, fy2;
  logic                 fdeg;
  logic signed [EW-1:0] cx1, cy1, cx2, cy2;
  logic signed [EW-1:0] off [4];
  logic signed [EW-1:0] lo_a, lo_b, hi_a, hi_b;
  logic [KW:0]          half;
  logic [OW-1:0]        xmin, xmax, ymin, ymax;
  logic                 vo_q;
  logic [lsbb_pkg::RES_W-1:0] res_q;

  always_comb begin
    {fx1, fy1, fx2, fy2, fdeg} = ms_q[KW-1];
    cx1 = to_fix(fx1);
    cy1 = to_fix(fy1);
    cx2 = to_fix(fx2);
    cy2 = to_fix(fy2);
    for (int l = 0; l < 4; l++) begin
      half   = ({1'b0, kk_q[KW-1][l]} + 1'b1) >> 1;
      off[l] = $signed(EW'(half));
    end
    lo_a = cx1 - off[0];
    lo_b = cx2 - off[2];
    xmin = sat((lo_a < lo_b) ? lo_a : lo_b);
    hi_a = cx1 + off[0];
    hi_b = cx2 + off[2];
    xmax = sat((hi_a > hi_b) ? hi_a : hi_b);
    lo_a = cy1 - off[1];
    lo_b = cy2 - off[3];
    ymin = sat((lo_a < lo_b) ? lo_a : lo_b);
    hi_a = cy1 + off[1];
    hi_b = cy2 + off[3];
    ymax = sat((hi_a > hi_b) ? hi_a : hi_b);
    if (fdeg) begin
      xmin = '0;
      xmax = '0;
      ymin = '0;
      ymax = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vs_q[KW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= {xmin, xmax, ymin, ymax, fdeg};
  end

  assign res_push_o = vo_q;
  assign res_data_o = res_q;

endmodule

/* sim/lane_segment_bounding_box_tb.sv */
// testbench for the lane segment bounding box block: directed table and random segments
module lane_segment_bounding_box_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 8;
  localparam int unsigned N_RANDOM = 1250;
  localparam int unsigned WATCHDOG = 20000;

  typedef struct packed {
    logic [lsbb_pkg::IN_W-1:0]  sx;
    logic [lsbb_pkg::IN_W-1:0]  sy;
    logic [lsbb_pkg::IN_W-1:0]  ex;
    logic [lsbb_pkg::IN_W-1:0]  ey;
    logic [lsbb_pkg::WID_W-1:0] sw;
    logic [lsbb_pkg::WID_W-1:0] ew;
  } segment_t;

  typedef struct packed {
    logic [lsbb_pkg::OUT_W-1:0] x_min;
    logic [lsbb_pkg::OUT_W-1:0] x_max;
    logic [lsbb_pkg::OUT_W-1:0] y_min;
    logic [lsbb_pkg::OUT_W-1:0] y_max;
    logic                       degen;
  } box_t;

  typedef struct packed {
    segment_t seg;
    logic     has_box;
    box_t     box;
  } row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  segment_t seg_q;
  box_t got;
  box_t pending_boxes[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned accepted_in = 0;
  int unsigned accepted_out = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  lane_segment_bounding_box i_dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .start_x_i(seg_q.sx), .start_y_i(seg_q.sy), .end_x_i(seg_q.ex), .end_y_i(seg_q.ey),
    .start_width_i(seg_q.sw), .end_width_i(seg_q.ew),
    .empty_o(empty), .pop_i(pop),
    .box_x_min_o(got.x_min), .box_x_max_o(got.x_max),
    .box_y_min_o(got.y_min), .box_y_max_o(got.y_max), .degenerate_o(got.degen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint whole_metre(logic [lsbb_pkg::IN_W-1:0] v);
    longint s, m;
    s = longint'(signed'(v));
    m = ((s < 0 ? -s : s) + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return s < 0 ? -m : m;
  endfunction

  // nearest integer to c*w/(2*sqrt(s)), halves up
  function automatic longint lane_offset(longint c, longint w, longint s);
    logic [127:0] rhs, lhs;
    longint lo, hi, q, t;
    lo = 0;
    hi = 2048;
    rhs = 128'(c * w) * 128'(c * w);
    while (lo < hi) begin
      q = (lo + hi + 1) >>> 1;
      t = 2 * q - 1;
      lhs = 128'(t * t) * 128'(s);
      if (lhs <= rhs) lo = q;
      else hi = q - 1;
    end
    return lo;
  endfunction

  function automatic logic [lsbb_pkg::OUT_W-1:0] clamp_edge(longint v);
    if (v < -8390656) v = -8390656;
    if (v > 8390655) v = 8390655;
    return lsbb_pkg::OUT_W'(v);
  endfunction

  function automatic box_t predict_box(segment_t g);
    box_t b;
    longint x1, y1, x2, y2, dx, dy, adx, ady, s, ox1, oy1, ox2, oy2;
    x1 = whole_metre(g.sx);
    y1 = whole_metre(g.sy);
    x2 = whole_metre(g.ex);
    y2 = whole_metre(g.ey);
    dx = x2 - x1;
    dy = y2 - y1;
    b = '0;
    if (dx == 0 && dy == 0) begin
      b.degen = 1'b1;
      return b;
    end
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    s = adx * adx + ady * ady;
    ox1 = lane_offset(ady, g.sw, s);
    oy1 = lane_offset(adx, g.sw, s);
    ox2 = lane_offset(ady, g.ew, s);
    oy2 = lane_offset(adx, g.ew, s);
    x1 = x1 << FRAC;
    y1 = y1 << FRAC;
    x2 = x2 << FRAC;
    y2 = y2 << FRAC;
    b.x_min = clamp_edge((x1 - ox1) < (x2 - ox2) ? x1 - ox1 : x2 - ox2);
    b.x_max = clamp_edge((x1 + ox1) > (x2 + ox2) ? x1 + ox1 : x2 + ox2);
    b.y_min = clamp_edge((y1 - oy1) < (y2 - oy2) ? y1 - oy1 : y2 - oy2);
    b.y_max = clamp_edge((y1 + oy1) > (y2 + oy2) ? y1 + oy1 : y2 + oy2);
    return b;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [lsbb_pkg::IN_W-1:0] rand_coord(int unsigned mode);
    case (mode)
      0: return lsbb_pkg::IN_W'($urandom);
      1: return lsbb_pkg::IN_W'($urandom_range(0, 2047) - 1024);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return lsbb_pkg::IN_W'(($urandom_range(0, 40) - 20) * 256
                                      + $urandom_range(0, 2) * 64);
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t g;
    int unsigned mode;
    mode = $urandom_range(0, 3);
    g.sx = rand_coord(mode);
    g.sy = rand_coord(mode);
    g.ex = rand_coord(mode);
    g.ey = rand_coord(mode);
    case ($urandom_range(0, 9))
      0: begin g.ex = g.sx; g.ey = g.sy; end
      1: g.ex = g.sx;
      2: g.ey = g.sy;
      default: ;
    endcase
    g.sw = lsbb_pkg::WID_W'($urandom);
    g.ew = $urandom_range(0, 4) == 0 ? 12'hfff : lsbb_pkg::WID_W'($urandom);
    return g;
  endfunction

  task automatic send_segment(segment_t g);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_q <= g;
    push  <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  row_t directed[$] = '{
    // zero length and small-distance rounding cases
    '{'{24'd0, 24'd0, 24'd0, 24'd0, 12'd0, 12'd0}, 1'b1, '{'0, '0, '0, '0, 1'b1}},
    '{'{24'd127, 24'd0, -24'sd127, 24'd0, 12'hfff, 12'hfff}, 1'b1,
      '{'0, '0, '0, '0, 1'b1}},
    '{'{24'd0, 24'd0, 24'd128, 24'd0, 12'd0, 12'd0}, 1'b1,
      '{25'd0, 25'd256, 25'd0, 25'd0, 1'b0}},
    '{'{24'd0, 24'd0, -24'sd128, 24'd0, 12'd512, 12'd0}, 1'b1,
      '{-25'sd256, 25'd0, -25'sd256, 25'd256, 1'b0}},
    // x max edge saturates on a vertical segment at the largest coordinate, then corner and general cases
    '{'{24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff, 12'hfff, 12'hfff}, 1'b0, '0},
    '{'{24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 12'hfff, 12'hfff}, 1'b0, '0},
    '{'{24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 12'd1, 12'hfff}, 1'b0, '0},
    '{'{24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 12'hfff, 12'd0}, 1'b0, '0},
    '{'{24'd256, 24'd512, 24'd1024, 24'd1280, 12'd384, 12'd640}, 1'b0, '0},
    '{'{24'hffff80, 24'd128, 24'd384, 24'hfffe80, 12'h800, 12'h7ff}, 1'b0, '0},
    '{'{24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 12'h555, 12'haaa}, 1'b0, '0}
  };

  initial begin
    segment_t g;
    box_t b;
    push  = 1'b0;
    seg_q = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      g = directed[i].seg;
      b = directed[i].has_box ? directed[i].box : predict_box(g);
      pending_boxes.insert(pending_boxes.size(), b);
      send_segment(g);
    end
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      g = rand_segment();
      pending_boxes.insert(pending_boxes.size(), predict_box(g));
      send_segment(g);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int unsigned gap;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off && accepted_in > 300 && accepted_in < 320) begin
        hold_off = 1'b1;
        pop <= 1'b0;
        repeat (200) @(posedge clk);
      end
      gap = $urandom_range(0, 3) == 0 ? pick_gap() : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    box_t want;
    if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (push && !full) begin
        accepted_in <= accepted_in + 1;
        idle_cycles <= 0;
      end
      if (pop && !empty) begin
        idle_cycles <= 0;
        accepted_out <= accepted_out + 1;
        if (pending_boxes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected box at %0t", $realtime);
        end else begin
          want = pending_boxes.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("box %0d: exp xmin %0d xmax %0d ymin %0d ymax %0d dg %0b, got %0d %0d %0d %0d %0b",
                       accepted_out, signed'(want.x_min), signed'(want.x_max),
                       signed'(want.y_min), signed'(want.y_max), want.degen,
                       signed'(got.x_min), signed'(got.x_max),
                       signed'(got.y_min), signed'(got.y_max), got.degen);
          end
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && pending_boxes.size() == 0) && idle_cycles < WATCHDOG)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (40) @(posedge clk);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
